@@ hdl/swk_pkg.sv @@
`timescale 1ns / 1ps

package swk_pkg;

    localparam int CORNER_W = 19;   // corner component, signed, scale 2^15
    localparam int RAD_W    = 36;   // sum of squares
    localparam int ROOT_W   = 18;   // magnitude
    localparam int REM_W    = 20;   // sqrt remainder
    localparam int SQ_STEPS = 18;   // one root bit per cell
    localparam int CORD_W   = 34;   // CORDIC x/y, corner * 4096 plus growth
    localparam int ATAN_N   = 24;
    localparam int SPEED_W  = 15;
    localparam int ANGLE_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_RATIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_RATIO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE  = 2'd2;

    localparam logic [15:0] RATIO_ONE = 16'd16384;

    typedef struct packed {
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic signed [15:0] turn_rate;
    } t_cmd;

    typedef struct packed {
        logic [SPEED_W-1:0]        front_left_speed;
        logic [SPEED_W-1:0]        back_left_speed;
        logic [SPEED_W-1:0]        front_right_speed;
        logic [SPEED_W-1:0]        back_right_speed;
        logic signed [ANGLE_W-1:0] front_left_angle;
        logic signed [ANGLE_W-1:0] back_left_angle;
        logic signed [ANGLE_W-1:0] front_right_angle;
        logic signed [ANGLE_W-1:0] back_right_angle;
    } t_res;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic [31:0]              z;
        logic                     zero;
    } t_cord;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } t_sqrt;

    // atan(2^-i) / pi * 2^31
    function automatic logic [31:0] swk_atan(input logic [4:0] idx);
        case (idx)
            5'd0:  swk_atan = 32'd536870912;
            5'd1:  swk_atan = 32'd316933406;
            5'd2:  swk_atan = 32'd167458907;
            5'd3:  swk_atan = 32'd85004756;
            5'd4:  swk_atan = 32'd42667331;
            5'd5:  swk_atan = 32'd21354465;
            5'd6:  swk_atan = 32'd10680862;
            5'd7:  swk_atan = 32'd5340245;
            5'd8:  swk_atan = 32'd2670163;
            5'd9:  swk_atan = 32'd1335087;
            5'd10: swk_atan = 32'd667544;
            5'd11: swk_atan = 32'd333772;
            5'd12: swk_atan = 32'd166886;
            5'd13: swk_atan = 32'd83443;
            5'd14: swk_atan = 32'd41722;
            5'd15: swk_atan = 32'd20861;
            5'd16: swk_atan = 32'd10430;
            5'd17: swk_atan = 32'd5215;
            5'd18: swk_atan = 32'd2608;
            5'd19: swk_atan = 32'd1304;
            5'd20: swk_atan = 32'd652;
            5'd21: swk_atan = 32'd326;
            5'd22: swk_atan = 32'd163;
            5'd23: swk_atan = 32'd81;
            default: swk_atan = 32'd0;
        endcase
    endfunction

endpackage

@@ hdl/swk_cordic_cell.sv @@
`timescale 1ns / 1ps

module swk_cordic_cell #(
    parameter int SHIFT  = 0,
    parameter bit ACTIVE = 1'b1
) (
    input  logic          i_clk,
    input  swk_pkg::t_cord i_d,
    output swk_pkg::t_cord o_q
);

    localparam logic [31:0] ATAN = swk_pkg::swk_atan(5'(SHIFT));

    swk_pkg::t_cord r_q;
    swk_pkg::t_cord n_q;

    always_comb begin
        n_q = i_d;
        if (ACTIVE) begin
            if (i_d.y >= 0) begin
                n_q.x = i_d.x + (i_d.y >>> SHIFT);
                n_q.y = i_d.y - (i_d.x >>> SHIFT);
                n_q.z = i_d.z + ATAN;
            end else begin
                n_q.x = i_d.x - (i_d.y >>> SHIFT);
                n_q.y = i_d.y + (i_d.x >>> SHIFT);
                n_q.z = i_d.z - ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

@@ hdl/swk_sqrt_cell.sv @@
`timescale 1ns / 1ps

module swk_sqrt_cell #(
    parameter int STEP   = 0,
    parameter bit ACTIVE = 1'b1
) (
    input  logic           i_clk,
    input  swk_pkg::t_sqrt i_d,
    output swk_pkg::t_sqrt o_q
);

    localparam int RW = swk_pkg::REM_W;
    localparam int PAIR_HI = (ACTIVE) ? swk_pkg::RAD_W - 1 - 2 * STEP : 1;

    swk_pkg::t_sqrt r_q;
    swk_pkg::t_sqrt n_q;
    logic [RW+1:0]  w_rem_s;
    logic [RW+1:0]  w_trial;

    always_comb begin
        w_rem_s = {i_d.rem, i_d.rad[PAIR_HI -: 2]};
        w_trial = {2'b00, i_d.root, 2'b01};
        n_q     = i_d;
        if (ACTIVE) begin
            if (w_rem_s >= w_trial) begin
                n_q.rem  = RW'(w_rem_s - w_trial);
                n_q.root = {i_d.root[swk_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_q.rem  = RW'(w_rem_s);
                n_q.root = {i_d.root[swk_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

@@ hdl/swerve_wheel_kinematics.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// command   in         i_start (o_busy low)   i_cmd    (t_cmd)
// result    out        o_strobe, one cycle    o_result (t_res)
// config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// One command per cycle; o_busy is always low. A command passes the product,
// corner and seed registers, the cell chain (18 active square-root cells and
// min(CORDIC_STAGES, 24) active CORDIC cells per wheel, side by side), then the
// scale and result registers. Reset sets all ratios to 1.0 and drops everything
// in flight. The receiver cannot stall; each result shows for one cycle.

module swerve_wheel_kinematics #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  swk_pkg::t_cmd                      i_cmd,
    output logic                               o_strobe,
    output swk_pkg::t_res                      o_result,
    input  logic                               i_cfg_we,
    input  logic [swk_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [15:0]                        i_cfg_data
);

    localparam int NST   = (CORDIC_STAGES > swk_pkg::ATAN_N) ? swk_pkg::ATAN_N
                                                              : CORDIC_STAGES;
    localparam int CHAIN = (NST > swk_pkg::SQ_STEPS) ? NST : swk_pkg::SQ_STEPS;
    localparam int CW    = swk_pkg::CORNER_W;
    localparam int KW    = swk_pkg::CORD_W;

    logic [15:0] r_length_ratio;
    logic [15:0] r_width_ratio;
    logic [15:0] r_speed_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_ratio <= swk_pkg::RATIO_ONE;
            r_width_ratio  <= swk_pkg::RATIO_ONE;
            r_speed_scale  <= swk_pkg::RATIO_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swk_pkg::CFG_LENGTH_RATIO: r_length_ratio <= i_cfg_data;
                swk_pkg::CFG_WIDTH_RATIO:  r_width_ratio  <= i_cfg_data;
                swk_pkg::CFG_SPEED_SCALE:  r_speed_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;
    logic w_acc;
    assign w_acc = i_start && !o_busy;

    // valid pipeline
    logic             r_v1, r_v2, r_v3, r_vf1, r_out_vld;
    logic [CHAIN-1:0] r_cv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_cv      <= '0;
            r_vf1     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_v1      <= w_acc;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_cv      <= {r_cv[CHAIN-2:0], r_v3};
            r_vf1     <= r_cv[CHAIN-1];
            r_out_vld <= r_vf1;
        end
    end

    // stage 1: rotation products
    logic signed [32:0] r_prod_l, r_prod_w;
    logic signed [15:0] r_mx, r_my;

    always_ff @(posedge i_clk) begin
        r_prod_l <= i_cmd.turn_rate * $signed({1'b0, r_length_ratio});
        r_prod_w <= i_cmd.turn_rate * $signed({1'b0, r_width_ratio});
        r_mx     <= i_cmd.move_x;
        r_my     <= i_cmd.move_y;
    end

    // stage 2: corner components, rounding halves up
    logic signed [32:0] w_rl, w_rw;
    logic signed [CW-1:0] w_tl, w_tw;
    logic signed [CW-1:0] r_a, r_b, r_c, r_d;

    always_comb begin
        w_rl = (r_prod_l + 33'sd8192) >>> 14;
        w_rw = (r_prod_w + 33'sd8192) >>> 14;
        w_tl = CW'(w_rl);
        w_tw = CW'(w_rw);
    end

    always_ff @(posedge i_clk) begin
        r_a <= CW'(r_mx) - w_tl;
        r_b <= CW'(r_mx) + w_tl;
        r_c <= CW'(r_my) - w_tw;
        r_d <= CW'(r_my) + w_tw;
    end

    // wheel order FL, BL, FR, BR: first = b,a,b,a; second = c,c,d,d
    logic signed [CW-1:0] w_p [4];
    logic signed [CW-1:0] w_q [4];

    assign w_p[0] = r_b;
    assign w_p[1] = r_a;
    assign w_p[2] = r_b;
    assign w_p[3] = r_a;
    assign w_q[0] = r_c;
    assign w_q[1] = r_c;
    assign w_q[2] = r_d;
    assign w_q[3] = r_d;

    // stage 3: squares and CORDIC seed
    swk_pkg::t_sqrt w_sq   [4][CHAIN+1];
    swk_pkg::t_cord w_cord [4][CHAIN+1];
    logic [2*CW-1:0] r_pp [4];
    logic [2*CW-1:0] r_qq [4];
    swk_pkg::t_cord r_seed [4];

    for (genvar w = 0; w < 4; w++) begin : g_wheel
        logic signed [KW-1:0] w_x, w_y;
        logic                 w_neg;

        always_comb begin
            w_neg = w_q[w] < 0;
            w_x   = w_neg ? -KW'(w_q[w]) : KW'(w_q[w]);
            w_y   = w_neg ? -KW'(w_p[w]) : KW'(w_p[w]);
        end

        always_ff @(posedge i_clk) begin
            r_pp[w]        <= $unsigned((2*CW)'(w_p[w]) * (2*CW)'(w_p[w]));
            r_qq[w]        <= $unsigned((2*CW)'(w_q[w]) * (2*CW)'(w_q[w]));
            r_seed[w].x    <= w_x <<< 12;
            r_seed[w].y    <= w_y <<< 12;
            r_seed[w].z    <= w_neg ? 32'h8000_0000 : 32'h0;
            r_seed[w].zero <= (w_p[w] == 0) && (w_q[w] == 0);
        end

        assign w_sq[w][0].rad  = swk_pkg::RAD_W'(r_pp[w] + r_qq[w]);
        assign w_sq[w][0].root = '0;
        assign w_sq[w][0].rem  = '0;
        assign w_cord[w][0]    = r_seed[w];

        for (genvar k = 0; k < CHAIN; k++) begin : g_cell
            swk_sqrt_cell #(
                .STEP   (k),
                .ACTIVE (k < swk_pkg::SQ_STEPS)
            ) u_sqrt (
                .i_clk (i_clk),
                .i_d   (w_sq[w][k]),
                .o_q   (w_sq[w][k+1])
            );

            swk_cordic_cell #(
                .SHIFT  (k),
                .ACTIVE (k < NST)
            ) u_cordic (
                .i_clk (i_clk),
                .i_d   (w_cord[w][k]),
                .o_q   (w_cord[w][k+1])
            );
        end
    end

    // final: scale, round, saturate
    logic [33:0] r_mag_prod [4];
    logic [31:0] r_z [4];
    logic [3:0]  r_zero;
    swk_pkg::t_res r_result;
    logic [swk_pkg::SPEED_W-1:0] w_speed [4];
    logic [swk_pkg::ANGLE_W-1:0] w_angle [4];

    for (genvar w = 0; w < 4; w++) begin : g_final
        logic [33:0] w_rs;
        logic [31:0] w_za;

        always_ff @(posedge i_clk) begin
            r_mag_prod[w] <= 34'(w_sq[w][CHAIN].root) * 34'(r_speed_scale);
            r_z[w]        <= w_cord[w][CHAIN].z;
            r_zero[w]     <= w_cord[w][CHAIN].zero;
        end

        always_comb begin
            w_rs       = (r_mag_prod[w] + 34'd8192) >> 14;
            w_za       = r_z[w] + 32'h8000;
            w_speed[w] = (w_rs > 34'd32767) ? 15'h7FFF : w_rs[14:0];
            w_angle[w] = r_zero[w] ? 16'h0 : w_za[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.front_left_speed  <= w_speed[0];
        r_result.back_left_speed   <= w_speed[1];
        r_result.front_right_speed <= w_speed[2];
        r_result.back_right_speed  <= w_speed[3];
        r_result.front_left_angle  <= w_angle[0];
        r_result.back_left_angle   <= w_angle[1];
        r_result.front_right_angle <= w_angle[2];
        r_result.back_right_angle  <= w_angle[3];
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_result;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vf1 |=> o_strobe) else $error("result transfer dropped");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vf1 |=> !o_strobe) else $error("result transfer without command");

    a_chain_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##3 r_v3) else $error("command lost before cell chain");

endmodule
